>>> rtl/wad_pkg.sv
// ----------------------------------------------------------------------------
// wad_pkg
// shared types and constants of the window alarm with delay timers
// ----------------------------------------------------------------------------
package wad_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned TIMERS   = 16;

  localparam logic signed [15:0] UNUSED_MARK = -16'sd32767;

  localparam logic [10:0] DELAY_MAX    = 11'd1092;
  localparam logic [15:0] MINUTE_TICKS = 16'd60;

  // sensor type codes
  localparam logic [1:0] TYPE_DIGITAL = 2'd0;
  localparam logic [1:0] TYPE_NTC     = 2'd1;
  localparam logic [1:0] TYPE_DIG_EXT = 2'd2;

  localparam logic [2:0] NTC_CHANNELS = 3'd3;
  localparam logic [2:0] EXT_FIRST    = 3'd5;

  // item kinds
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // register indexes
  localparam logic [2:0] REG_TEMP_UPPER    = 3'd0;
  localparam logic [2:0] REG_TEMP_LOWER    = 3'd1;
  localparam logic [2:0] REG_HUMI_UPPER    = 3'd2;
  localparam logic [2:0] REG_HUMI_LOWER    = 3'd3;
  localparam logic [2:0] REG_DELAY_MINUTES = 3'd4;
  localparam logic [2:0] REG_SENSOR_TYPE   = 3'd5;
  localparam logic [2:0] REG_ACTIVE_COUNT  = 3'd6;
  localparam logic [2:0] REG_INVALID_MARK  = 3'd7;

  typedef struct packed {
    logic signed [15:0] temp_upper;
    logic signed [15:0] temp_lower;
    logic signed [15:0] humi_upper;
    logic signed [15:0] humi_lower;
    logic [10:0]        delay_minutes;
    logic [1:0]         sensor_type;
    logic [3:0]         active_count;
    logic signed [15:0] invalid_mark;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] humi_value;
    logic signed [15:0] temp_value;
    logic [2:0]         channel;
    logic               command;
  } item_t;

  typedef struct packed {
    logic [7:0] humi_out_mask;
    logic [7:0] temp_out_mask;
    logic [7:0] humi_alarm_mask;
    logic [7:0] temp_alarm_mask;
  } result_t;

  // handshake between the stages
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stage_ctl_t;

  function automatic logic chan_active(input logic [2:0] c, input cfg_t cfg);
    logic act;
    act = 1'b0;
    if ({1'b0, c} < 4'(CHANNELS)) begin
      if (cfg.sensor_type == TYPE_NTC) begin
        act = (c < NTC_CHANNELS);
      end else begin
        act = ({1'b0, c} < cfg.active_count) ||
              (cfg.sensor_type == TYPE_DIG_EXT && c >= EXT_FIRST);
      end
    end
    return act;
  endfunction

endpackage

>>> rtl/window_alarm_with_delay.sv
// ----------------------------------------------------------------------------
// window_alarm_with_delay
// eight-channel temperature and humidity window alarm with delay timers
//
//   group    dir  payload
//   s_axis   in   tuser: command; tdata: channel, temp_value, humi_value
//   m_axis   out  tdata: temp/humi alarm masks, temp/humi out masks
//   cfg      in   cfg_we, cfg_index, cfg_data
//
// one transaction per cycle sustained while the master side takes results;
// a result is offered once its input has passed the input register, then
// the result register
// rst is synchronous and clears masks, timers, config and both stages
// a stalled master side holds the result; the input register still fills
// ----------------------------------------------------------------------------
module window_alarm_with_delay
  import wad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // channel, temp_value, humi_value, zero pad
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // temp_alarm, humi_alarm, temp_out, humi_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg;
  item_t      in_item, item;
  result_t    res, out_res;
  stage_ctl_t ctl;
  logic       go, in_vld, out_free;

  assign in_item.command    = s_axis_tuser;
  assign in_item.channel    = s_axis_tdata[2:0];
  assign in_item.temp_value = s_axis_tdata[18:3];
  assign in_item.humi_value = s_axis_tdata[34:19];

  assign ctl.in_valid = in_vld;
  assign ctl.out_free = out_free;

  wad_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wad_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .take     (go),
    .vld      (in_vld),
    .item     (item)
  );

  wad_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .ctl  (ctl),
    .item (item),
    .go   (go),
    .res  (res)
  );

  wad_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (go),
    .res       (res),
    .free      (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = out_res;

endmodule

>>> rtl/wad_cfg.sv
// ----------------------------------------------------------------------------
// wad_cfg
// configuration register file, written by index
// ----------------------------------------------------------------------------
module wad_cfg
  import wad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_UPPER:    cfg.temp_upper    <= cfg_data;
        REG_TEMP_LOWER:    cfg.temp_lower    <= cfg_data;
        REG_HUMI_UPPER:    cfg.humi_upper    <= cfg_data;
        REG_HUMI_LOWER:    cfg.humi_lower    <= cfg_data;
        REG_DELAY_MINUTES: cfg.delay_minutes <= cfg_data[10:0];
        REG_SENSOR_TYPE:   cfg.sensor_type   <= cfg_data[1:0];
        REG_ACTIVE_COUNT:  cfg.active_count  <= cfg_data[3:0];
        REG_INVALID_MARK:  cfg.invalid_mark  <= cfg_data;
        default:           cfg.invalid_mark  <= cfg.invalid_mark;
      endcase
    end
  end

endmodule

>>> rtl/wad_in_stage.sv
// ----------------------------------------------------------------------------
// wad_in_stage
// input register, refilled in the cycle it is consumed
// ----------------------------------------------------------------------------
module wad_in_stage
  import wad_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  vld,
  output item_t item
);

  assign in_ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> rtl/wad_core.sv
// ----------------------------------------------------------------------------
// wad_core
// channel masks, sixteen delay timers and the per-item update
// ----------------------------------------------------------------------------
module wad_core
  import wad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  stage_ctl_t ctl,
  input  item_t      item,
  output logic       go,
  output result_t    res
);

  logic [7:0]  temp_out, humi_out, temp_alarm, humi_alarm;
  logic [7:0]  temp_out_next, humi_out_next, temp_alarm_next, humi_alarm_next;
  logic [15:0] cnt [TIMERS];
  logic [15:0] cnt_next [TIMERS];
  logic [TIMERS-1:0] run, run_next, expd, expd_next;

  logic [10:0] mins;
  logic [15:0] limit;
  logic [7:0]  active;
  logic [2:0]  ch;
  logic [3:0]  th;
  logic        t_skip, h_skip, t_outside, h_outside;

  assign go = ctl.in_valid && ctl.out_free;
  assign ch = item.channel;
  assign th = {1'b1, ch};

  assign mins  = (cfg.delay_minutes > DELAY_MAX) ? DELAY_MAX : cfg.delay_minutes;
  assign limit = 16'(mins) * MINUTE_TICKS;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      active[c] = chan_active(3'(c), cfg);
    end
  end

  assign t_skip = (item.temp_value == cfg.invalid_mark) ||
                  (cfg.sensor_type != TYPE_NTC && item.temp_value == UNUSED_MARK);
  assign h_skip = (item.humi_value == cfg.invalid_mark) ||
                  (cfg.sensor_type != TYPE_NTC && item.humi_value == UNUSED_MARK);
  assign t_outside = (item.temp_value > cfg.temp_upper) ||
                     (item.temp_value < cfg.temp_lower);
  assign h_outside = (item.humi_value > cfg.humi_upper) ||
                     (item.humi_value < cfg.humi_lower);

  always_comb begin
    temp_out_next   = temp_out;
    humi_out_next   = humi_out;
    temp_alarm_next = temp_alarm;
    humi_alarm_next = humi_alarm;
    cnt_next        = cnt;
    run_next        = run;
    expd_next       = expd;
    if (go) begin
      if (item.command == CMD_TICK) begin
        for (int t = 0; t < TIMERS; t++) begin
          if (run[t]) begin
            cnt_next[t] = cnt[t] + 16'd1;
            if (cnt_next[t] > limit) begin
              expd_next[t] = 1'b1;
              run_next[t]  = 1'b0;
            end
          end
        end
      end else begin
        // inactive channels are cleared on every sample
        for (int c = 0; c < 8; c++) begin
          if (!active[c]) begin
            temp_out_next[c]   = 1'b0;
            humi_out_next[c]   = 1'b0;
            temp_alarm_next[c] = 1'b0;
            humi_alarm_next[c] = 1'b0;
            cnt_next[c]        = '0;
            run_next[c]        = 1'b0;
            expd_next[c]       = 1'b0;
            cnt_next[c+8]      = '0;
            run_next[c+8]      = 1'b0;
            expd_next[c+8]     = 1'b0;
          end
        end
        if (active[ch]) begin
          if (!t_skip) begin
            if (t_outside) begin
              if (!temp_out[ch]) begin
                cnt_next[{1'b0, ch}]  = '0;
                run_next[{1'b0, ch}]  = 1'b1;
                expd_next[{1'b0, ch}] = 1'b0;
              end
              temp_out_next[ch] = 1'b1;
            end else begin
              temp_out_next[ch]     = 1'b0;
              temp_alarm_next[ch]   = 1'b0;
              cnt_next[{1'b0, ch}]  = '0;
              run_next[{1'b0, ch}]  = 1'b0;
              expd_next[{1'b0, ch}] = 1'b0;
            end
          end
          if (!h_skip) begin
            if (h_outside) begin
              if (!humi_out[ch]) begin
                cnt_next[th]  = '0;
                run_next[th]  = 1'b1;
                expd_next[th] = 1'b0;
              end
              humi_out_next[ch] = 1'b1;
            end else begin
              humi_out_next[ch]   = 1'b0;
              humi_alarm_next[ch] = 1'b0;
              cnt_next[th]        = '0;
              run_next[th]        = 1'b0;
              expd_next[th]       = 1'b0;
            end
          end
        end
        // an expired timer latches the alarm of the sampled channel
        if (expd_next[{1'b0, ch}]) begin
          expd_next[{1'b0, ch}] = 1'b0;
          temp_alarm_next[ch]   = 1'b1;
        end
        if (expd_next[th]) begin
          expd_next[th]       = 1'b0;
          humi_alarm_next[ch] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_out   <= '0;
      humi_out   <= '0;
      temp_alarm <= '0;
      humi_alarm <= '0;
      run        <= '0;
      expd       <= '0;
    end else begin
      temp_out   <= temp_out_next;
      humi_out   <= humi_out_next;
      temp_alarm <= temp_alarm_next;
      humi_alarm <= humi_alarm_next;
      run        <= run_next;
      expd       <= expd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '{default: '0};
    end else begin
      cnt <= cnt_next;
    end
  end

  assign res.temp_alarm_mask = temp_alarm_next;
  assign res.humi_alarm_mask = humi_alarm_next;
  assign res.temp_out_mask   = temp_out_next;
  assign res.humi_out_mask   = humi_out_next;

endmodule

>>> rtl/wad_out_stage.sv
// ----------------------------------------------------------------------------
// wad_out_stage
// result register holding one transaction for the master side
// ----------------------------------------------------------------------------
module wad_out_stage
  import wad_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule
